/* hdl/tiq_pkg.sv */
// Shared package for the timed transfer interval queue.
// Holds sizes, command codes and controller/datapath interface structs.
`timescale 1ns / 1ps
package tiq_pkg;

    localparam int unsigned QUEUE_DEPTH = 16;
    localparam int unsigned IW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned TW = 32;
    localparam int unsigned SW = 36;
    localparam logic [SW-1:0] SUM_MAX = {SW{1'b1}};

    typedef logic [1:0] t_op;
    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_CHECK  = 2'd1;
    localparam t_op OP_DRAIN  = 2'd2;

    typedef struct packed {
        logic load_in;
        logic set_drop;
        logic scan_init;
        logic scan_step;
        logic ins_write;
        logic chk_init;
        logic chk_step;
        logic drn_init;
        logic drn_whole;
        logic mul_start;
        logic div_init;
        logic div_step;
        logic drn_part;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic full;
        logic scan_done;
        logic chk_done;
        logic drn_done;
        logic drn_whole;
        logic div_last;
    } t_dp_sts;

endpackage

/* hdl/tiq_dpath.sv */
// Datapath: interval storage, scan pointers, multiplier and serial divider.
// Depends on tiq_pkg; driven by tiq_ctrl through command/status structs.
`timescale 1ns / 1ps
module tiq_dpath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  tiq_pkg::t_dp_cmd         i_cmd,
    output tiq_pkg::t_dp_sts         o_sts,
    input  tiq_pkg::t_op             i_command,
    input  logic [tiq_pkg::TW-1:0]   i_transfer_start,
    input  logic [tiq_pkg::TW-1:0]   i_transfer_end,
    input  logic [tiq_pkg::TW-1:0]   i_transfer_amount,
    input  logic [tiq_pkg::TW-1:0]   i_now_time,
    input  logic [tiq_pkg::TW-1:0]   i_step_end_time,
    output logic                     o_all_arrived,
    output logic [tiq_pkg::SW-1:0]   o_drained_amount,
    output logic                     o_status
);
    localparam int unsigned D  = tiq_pkg::QUEUE_DEPTH;
    localparam int unsigned IW = tiq_pkg::IW;
    localparam int unsigned CW = tiq_pkg::CW;
    localparam int unsigned TW = tiq_pkg::TW;
    localparam int unsigned SW = tiq_pkg::SW;

    logic [TW-1:0] r_slot_start  [D];
    logic [TW-1:0] r_slot_end    [D];
    logic [TW-1:0] r_slot_amount [D];
    logic [CW-1:0] r_count;

    tiq_pkg::t_op  r_op;
    logic [TW-1:0] r_s, r_e, r_a, r_now, r_step;
    logic          r_drop;
    logic [IW-1:0] r_pos;
    logic [CW-1:0] r_i;
    logic          r_ok;
    logic [TW-1:0] r_reached;
    logic [SW-1:0] r_sum;
    logic [2*TW-1:0] r_prod;
    logic [TW-1:0] r_den;
    logic [TW-1:0] r_rem;
    logic [TW-1:0] r_dq;
    logic [4:0]    r_bit;

    logic [IW-1:0] w_prev;
    logic [TW-1:0] w_chk_start, w_chk_end;
    logic [TW:0]   w_trial;
    logic          w_ge;
    logic [SW:0]   w_add;
    logic [SW-1:0] w_sum_sat;
    logic [TW-1:0] w_addend;

    assign w_prev      = r_pos - IW'(1);
    assign w_chk_start = r_slot_start[r_i[IW-1:0]];
    assign w_chk_end   = r_slot_end[r_i[IW-1:0]];
    assign w_trial     = {r_rem, r_dq[TW-1]};
    assign w_ge        = w_trial >= {1'b0, r_den};
    assign w_addend    = i_cmd.drn_whole ? r_slot_amount[0] : r_dq;
    assign w_add       = {1'b0, r_sum} + (SW+1)'(w_addend);
    assign w_sum_sat   = w_add[SW] ? tiq_pkg::SUM_MAX : w_add[SW-1:0];

    always_comb begin
        o_sts.op        = r_op;
        o_sts.full      = r_count == CW'(D);
        o_sts.scan_done = (r_pos == '0) || (r_slot_end[w_prev] <= r_s);
        o_sts.chk_done  = !r_ok || (r_i == r_count) || (r_reached >= r_step);
        o_sts.drn_done  = (r_count == '0) || (r_slot_start[0] >= r_step);
        o_sts.drn_whole = r_slot_end[0] <= r_step;
        o_sts.div_last  = r_bit == 5'd31;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.ins_write) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.drn_whole) begin
            r_count <= r_count - CW'(1);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < D; i++) begin
            if (i_cmd.ins_write) begin
                if (i == int'(r_pos)) begin
                    r_slot_start[i]  <= r_s;
                    r_slot_end[i]    <= r_e;
                    r_slot_amount[i] <= r_a;
                end else if (i > int'(r_pos)) begin
                    r_slot_start[i]  <= r_slot_start[(i > 0) ? i-1 : 0];
                    r_slot_end[i]    <= r_slot_end[(i > 0) ? i-1 : 0];
                    r_slot_amount[i] <= r_slot_amount[(i > 0) ? i-1 : 0];
                end
            end else if (i_cmd.drn_whole) begin
                if (i < D - 1) begin
                    r_slot_start[i]  <= r_slot_start[(i < D - 1) ? i+1 : i];
                    r_slot_end[i]    <= r_slot_end[(i < D - 1) ? i+1 : i];
                    r_slot_amount[i] <= r_slot_amount[(i < D - 1) ? i+1 : i];
                end
            end else if (i_cmd.drn_part && i == 0) begin
                r_slot_start[0]  <= r_step;
                r_slot_amount[0] <= r_slot_amount[0] - r_dq;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= i_command;
            r_s    <= i_transfer_start;
            r_e    <= i_transfer_end;
            r_a    <= i_transfer_amount;
            r_now  <= i_now_time;
            r_step <= i_step_end_time;
            r_drop <= 1'b0;
        end
        if (i_cmd.set_drop) r_drop <= 1'b1;
        if (i_cmd.scan_init) r_pos <= r_count[IW-1:0];
        if (i_cmd.scan_step) r_pos <= w_prev;
        if (i_cmd.chk_init) begin
            r_ok      <= r_count != '0;
            r_reached <= r_now;
            r_i       <= '0;
        end
        if (i_cmd.chk_step) begin
            if (r_reached != w_chk_start) r_ok <= 1'b0;
            else                          r_reached <= w_chk_end;
            r_i <= r_i + CW'(1);
        end
        if (i_cmd.drn_init) r_sum <= '0;
        if (i_cmd.drn_whole || i_cmd.drn_part) r_sum <= w_sum_sat;
        if (i_cmd.mul_start) begin
            r_prod <= (2*TW)'(r_slot_amount[0]) * (2*TW)'(r_step - r_slot_start[0]);
            r_den  <= r_slot_end[0] - r_slot_start[0];
        end
        if (i_cmd.div_init) begin
            r_rem <= r_prod[2*TW-1:TW];
            r_dq  <= r_prod[TW-1:0];
            r_bit <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? TW'(w_trial - {1'b0, r_den}) : w_trial[TW-1:0];
            r_dq  <= {r_dq[TW-2:0], w_ge};
            r_bit <= r_bit + 5'd1;
        end
        if (i_cmd.out_load) begin
            o_all_arrived    <= (r_op == tiq_pkg::OP_CHECK) && r_ok && (r_reached >= r_step);
            o_drained_amount <= (r_op == tiq_pkg::OP_DRAIN) ? r_sum : '0;
            o_status         <= (r_op == tiq_pkg::OP_INSERT) && r_drop;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(D))
        else $error("entry count above depth");
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_write |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow queue");
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> r_rem < r_den)
        else $error("divider remainder out of range");
`endif

endmodule

/* hdl/tiq_ctrl.sv */
// Controller state machine for the timed transfer interval queue.
// Depends on tiq_pkg; issues commands to tiq_dpath and owns the handshakes.
`timescale 1ns / 1ps
module tiq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  tiq_pkg::t_dp_sts  i_sts,
    output tiq_pkg::t_dp_cmd  o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_IWR   = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_DTEST = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_UPD   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_sts.op)
                    tiq_pkg::OP_INSERT: begin
                        if (i_sts.full) begin
                            o_cmd.set_drop = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.scan_init = 1'b1;
                            n_state = S_SCAN;
                        end
                    end
                    tiq_pkg::OP_CHECK: begin
                        o_cmd.chk_init = 1'b1;
                        n_state = S_CHK;
                    end
                    tiq_pkg::OP_DRAIN: begin
                        o_cmd.drn_init = 1'b1;
                        n_state = S_DTEST;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_IWR;
                else                 o_cmd.scan_step = 1'b1;
            end
            S_IWR: begin
                o_cmd.ins_write = 1'b1;
                n_state = S_DONE;
            end
            S_CHK: begin
                if (i_sts.chk_done) n_state = S_DONE;
                else                o_cmd.chk_step = 1'b1;
            end
            S_DTEST: begin
                if (i_sts.drn_done) begin
                    n_state = S_DONE;
                end else if (i_sts.drn_whole) begin
                    o_cmd.drn_whole = 1'b1;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.drn_part = 1'b1;
                n_state = S_DTEST;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = o_cmd.out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_state == S_IDLE && r_out_valid)
        else $error("result load did not return to idle");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> $past(r_state) == S_DIV && i_sts.div_last == 1'b0)
        else $error("partial update without finished divide");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before transfer");
`endif

endmodule

/* hdl/timed_transfer_interval_queue_unit.sv */
// Sequence: insert loads, dispatches, scans from the tail for its slot and writes;
// check walks the entries; drain removes each whole interval, then splits a straddling one
// (32-step restoring divider after a registered 32x32 multiply).
// Throughput: one item at a time; a new transfer is taken as soon as the
// controller is idle, while a finished result may still wait at the output.
// Reset: synchronous, active low; clears the entry count and control state.
`timescale 1ns / 1ps
module timed_transfer_interval_queue_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_command,
    input  logic [31:0]            i_transfer_start,
    input  logic [31:0]            i_transfer_end,
    input  logic [31:0]            i_transfer_amount,
    input  logic [31:0]            i_now_time,
    input  logic [31:0]            i_step_end_time,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_all_arrived,
    output logic [35:0]            o_drained_amount,
    output logic                   o_status
);
    // Controller sequences insert scan, coverage walk and drain loop;
    // datapath holds the sorted interval registers and arithmetic.
    tiq_pkg::t_dp_cmd w_cmd;
    tiq_pkg::t_dp_sts w_sts;

    tiq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    tiq_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_command         (i_command),
        .i_transfer_start  (i_transfer_start),
        .i_transfer_end    (i_transfer_end),
        .i_transfer_amount (i_transfer_amount),
        .i_now_time        (i_now_time),
        .i_step_end_time   (i_step_end_time),
        .o_all_arrived     (o_all_arrived),
        .o_drained_amount  (o_drained_amount),
        .o_status          (o_status)
    );

endmodule
